/* rtl/bspq_pkg.sv */
// ----------------------------------------------------------------------------
// bspq_pkg
// Shared types and constants for the bounded sorted priority queue.
// ----------------------------------------------------------------------------
package bspq_pkg;

  // storage geometry
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int KEY_W = 32;
  localparam int PAY_W = 32;

  // stream payload widths (whole bytes)
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 80;

  // request codes
  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_FIND   = 3'd2,
    REQ_READ   = 3'd3,
    REQ_CLEAR  = 3'd4
  } req_t;

  // result status codes
  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_DROPPED  = 2'd1,
    STS_NOTFOUND = 2'd2,
    STS_BADPOS   = 2'd3
  } status_t;

  // register index of capacity
  localparam logic REG_CAPACITY = 1'b0;

  // capacity as used: zero acts as one, anything above the depth as the depth
  function automatic logic [CNT_W-1:0] eff_cap(input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] res;
    if (cap == '0) begin
      res = CNT_W'(1);
    end else if (cap > CNT_W'(DEPTH)) begin
      res = CNT_W'(DEPTH);
    end else begin
      res = cap;
    end
    return res;
  endfunction

endpackage

/* rtl/bounded_sorted_priority_queue_core.sv */
// ----------------------------------------------------------------------------
// bounded_sorted_priority_queue_core
// Up to sixteen key/payload entries kept in ascending key order, served by a
// small sequencer around one key comparator, one read port and one write port.
// ----------------------------------------------------------------------------
// Each request gives one result. A request is taken while the block is idle;
// its result is moved from the pending-result registers into the output
// register in the response state once that register is free. The sequencer
// walks the entries one place per cycle through the shared comparator and
// the read and write ports: insert moves stored entries with larger keys up
// one place, remove moves later entries down, find searches up to the place
// found (or the entry count when absent); read, clear and unknown requests go
// straight to the response state. The next request is taken in the cycle
// after the output register is loaded, even while the result waits. The user
// must write capacity only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module bounded_sorted_priority_queue_core
  import bspq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // key_in[31:0], payload_in[63:32], position_in[67:64], zero fill above
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // req_type[2:0]
  input  logic [2:0]            in_tuser,
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // position_out[3:0], key_out[35:4], payload_out[67:36], count_out[72:68],
  // zero fill above
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [1:0]            out_tuser,
  // configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [2:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_INS  = 5'b00010,
    ST_REM  = 5'b00100,
    ST_FIND = 5'b01000,
    ST_RESP = 5'b10000
  } state_t;

  // entry storage
  logic [KEY_W-1:0] keys_r [DEPTH];
  logic [PAY_W-1:0] pays_r [DEPTH];

  // control
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] cap_r, cap_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             drop_r, drop_nxt;

  // latched request
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [PAY_W-1:0] pay_r, pay_nxt;

  // pending result
  status_t          res_status_r, res_status_nxt;
  logic [IDX_W-1:0] res_pos_r, res_pos_nxt;
  logic [KEY_W-1:0] res_key_r, res_key_nxt;
  logic [PAY_W-1:0] res_pay_r, res_pay_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [IDX_W-1:0] out_pos_r, out_pos_nxt;
  logic [KEY_W-1:0] out_key_r, out_key_nxt;
  logic [PAY_W-1:0] out_pay_r, out_pay_nxt;
  logic [CNT_W-1:0] out_count_r, out_count_nxt;

  // unpacked request fields
  logic [KEY_W-1:0] in_key;
  logic [PAY_W-1:0] in_pay;
  logic [IDX_W-1:0] in_pos;
  req_t             in_req;

  // shared read port, comparator and write port
  logic [IDX_W-1:0] rd_addr;
  logic [KEY_W-1:0] rd_key;
  logic [PAY_W-1:0] rd_pay;
  logic             cmp_gt;
  logic             cmp_eq;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [KEY_W-1:0] wr_key;
  logic [PAY_W-1:0] wr_pay;

  logic             in_acc;
  logic             cfg_wr;
  logic [CNT_W-1:0] cap_eff;
  logic [CNT_W-1:0] cap_new;

  assign in_key = in_tdata[31:0];
  assign in_pay = in_tdata[63:32];
  assign in_pos = in_tdata[67:64];
  assign in_req = req_t'(in_tuser);

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == REG_CAPACITY);
  assign cfg_prdata = (cfg_paddr[2] == REG_CAPACITY) ? {{(32-CNT_W){1'b0}}, cap_r} : '0;
  assign cap_eff    = eff_cap(cap_r);
  assign cap_new    = eff_cap(cfg_pwdata[CNT_W-1:0]);

  // read address follows the sequencer step
  always_comb begin
    unique case (state_r)
      ST_INS:  rd_addr = IDX_W'(idx_r - CNT_W'(1));
      ST_REM:  rd_addr = IDX_W'(idx_r + CNT_W'(1));
      ST_FIND: rd_addr = idx_r[IDX_W-1:0];
      default: rd_addr = in_pos;
    endcase
  end

  assign rd_key = keys_r[rd_addr];
  assign rd_pay = pays_r[rd_addr];

  // shared key comparator
  assign cmp_gt = (rd_key > key_r);
  assign cmp_eq = (rd_key == key_r);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cap_nxt        = cap_r;
    idx_nxt        = idx_r;
    drop_nxt       = drop_r;
    key_nxt        = key_r;
    pay_nxt        = pay_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    res_key_nxt    = res_key_r;
    res_pay_nxt    = res_pay_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_key_nxt    = out_key_r;
    out_pay_nxt    = out_pay_r;
    out_count_nxt  = out_count_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r[IDX_W-1:0];
    wr_key         = rd_key;
    wr_pay         = rd_pay;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          key_nxt        = in_key;
          pay_nxt        = in_pay;
          res_status_nxt = STS_OK;
          res_pos_nxt    = '0;
          res_key_nxt    = '0;
          res_pay_nxt    = '0;
          state_nxt      = ST_RESP;
          unique case (in_req)
            REQ_INSERT: begin
              drop_nxt  = (count_r >= cap_eff);
              idx_nxt   = (count_r >= cap_eff) ? cap_eff - CNT_W'(1) : count_r;
              state_nxt = ST_INS;
            end
            REQ_REMOVE: begin
              if ({1'b0, in_pos} >= count_r) begin
                res_status_nxt = STS_BADPOS;
              end else begin
                idx_nxt   = {1'b0, in_pos};
                state_nxt = ST_REM;
              end
            end
            REQ_FIND: begin
              idx_nxt   = '0;
              state_nxt = ST_FIND;
            end
            REQ_READ: begin
              if ({1'b0, in_pos} >= count_r) begin
                res_status_nxt = STS_BADPOS;
              end else begin
                res_pos_nxt = in_pos;
                res_key_nxt = rd_key;
                res_pay_nxt = rd_pay;
              end
            end
            REQ_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // walk down from the top, moving larger keys up one place
      ST_INS: begin
        wr_en = 1'b1;
        if ((idx_r != '0) && cmp_gt) begin
          idx_nxt = idx_r - CNT_W'(1);
        end else begin
          wr_key         = key_r;
          wr_pay         = pay_r;
          res_pos_nxt    = idx_r[IDX_W-1:0];
          res_status_nxt = drop_r ? STS_DROPPED : STS_OK;
          if (!drop_r) begin
            count_nxt = count_r + CNT_W'(1);
          end
          state_nxt = ST_RESP;
        end
      end

      // move later entries down one place
      ST_REM: begin
        if ((idx_r + CNT_W'(1)) < count_r) begin
          wr_en   = 1'b1;
          idx_nxt = idx_r + CNT_W'(1);
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = ST_RESP;
        end
      end

      // linear search from the smallest key
      ST_FIND: begin
        if (idx_r < count_r) begin
          if (cmp_eq) begin
            res_pos_nxt = idx_r[IDX_W-1:0];
            res_key_nxt = rd_key;
            res_pay_nxt = rd_pay;
            state_nxt   = ST_RESP;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end else begin
          res_status_nxt = STS_NOTFOUND;
          state_nxt      = ST_RESP;
        end
      end

      // hand the result to the output register once it is free
      ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_pos_nxt    = res_pos_r;
          out_key_nxt    = res_key_r;
          out_pay_nxt    = res_pay_r;
          out_count_nxt  = count_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // capacity write clamps the count
    if (cfg_wr) begin
      cap_nxt = cfg_pwdata[CNT_W-1:0];
      if (count_r > cap_new) begin
        count_nxt = cap_new;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cap_r       <= CNT_W'(DEPTH);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    drop_r       <= drop_nxt;
    key_r        <= key_nxt;
    pay_r        <= pay_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    res_key_r    <= res_key_nxt;
    res_pay_r    <= res_pay_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_key_r    <= out_key_nxt;
    out_pay_r    <= out_pay_nxt;
    out_count_r  <= out_count_nxt;
  end

  // entry write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      keys_r[wr_addr] <= wr_key;
      pays_r[wr_addr] <= wr_pay;
    end
  end

  // result packing
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(OUT_DATA_W-IDX_W-KEY_W-PAY_W-CNT_W){1'b0}},
                       out_count_r, out_pay_r, out_key_r, out_pos_r};

endmodule

/* rtl/bspq_checker.sv */
// ----------------------------------------------------------------------------
// bspq_checker
// Port-level checks on the bounded sorted priority queue.
// ----------------------------------------------------------------------------
module bspq_checker
  import bspq_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]            out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // the sequencer is busy in the cycle after an item is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after an accepted item");

  // entry count never exceeds the depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[72:68] <= 5'd16)
    else $error("count above depth");

  // a dropped-largest insert leaves the queue non-empty
  a_drop_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STS_DROPPED) |-> out_tdata[72:68] != 5'd0)
    else $error("drop reported on an empty queue");

  // a failed lookup carries no entry
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tuser == STS_NOTFOUND) || (out_tuser == STS_BADPOS)) |->
      (out_tdata[67:0] == 68'd0))
    else $error("failed request carries entry data");

endmodule

bind bounded_sorted_priority_queue_core bspq_checker u_bspq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
